[rtl/core/pcmosc_pkg.sv]
// Shared types, widths and constants for the PCM output sample converter.
// Depends on nothing; imported by the converter core and its port checker.
package pcmosc_pkg;

  localparam int unsigned SRC_COUNT       = 6;
  localparam int unsigned MAX_DEV         = 8;
  localparam int unsigned IN_W            = 24;
  localparam int unsigned INPUT_FRAC_BITS = 20;
  localparam int unsigned GAIN_FRAC_BITS  = 12;
  localparam int unsigned GAIN_W          = 16;
  localparam int unsigned SHIFT           = INPUT_FRAC_BITS + GAIN_FRAC_BITS;
  localparam int unsigned SUM_W           = IN_W + 3;
  localparam int unsigned MAG_W           = SUM_W;
  localparam int unsigned X_W             = MAG_W + GAIN_W;
  localparam int unsigned FULL_MAX_BITS   = 31;
  localparam int unsigned P_W             = X_W + FULL_MAX_BITS;
  localparam int unsigned DIV_STAGES      = 5;
  localparam int unsigned DIV_STEP        = 7;
  localparam int unsigned Q_W             = DIV_STAGES * DIV_STEP;
  localparam int unsigned V_W             = Q_W + 2;
  localparam int unsigned PCM_W           = 32;
  localparam int unsigned CH_W            = 3;
  localparam int unsigned DEV_W           = 4;
  localparam int unsigned SRCN_W          = 3;
  localparam int unsigned MODE_W          = 2;
  localparam int unsigned CFG_IDX_W       = 3;
  localparam int unsigned CFG_DATA_W      = 16;

  // Any quotient of 2^32 or more saturates alike, so the dividend is capped at 5 * 2^32.
  localparam logic [Q_W-1:0] Q_CLAMP = 35'h5_0000_0000;
  localparam logic [3:0]     DIVISOR = 4'd5;

  localparam logic [MODE_W-1:0] RST_MODE   = 2'd1;
  localparam logic [GAIN_W-1:0] RST_GAIN   = 16'd4096;
  localparam logic [SRCN_W-1:0] RST_SRC_CH = 3'd2;
  localparam logic [DEV_W-1:0]  RST_DEV_CH = 4'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAMPLE_BITS_MODE = 3'd0,
    CFG_PLAY_GAIN        = 3'd1,
    CFG_DOWNMIX_ENABLE   = 3'd2,
    CFG_DITHER_ENABLE    = 3'd3,
    CFG_SOURCE_CHANNELS  = 3'd4,
    CFG_DEVICE_CHANNELS  = 3'd5
  } cfg_index_e;

  typedef struct packed {
    logic [CH_W-1:0] ch;
    logic            last;
    logic            dith;
    logic            mix;
    logic            neg;
  } item_tag_t;

  function automatic logic [4:0] full_shift(input logic [MODE_W-1:0] mode);
    logic [4:0] k;
    case (mode)
      2'd0:    k = 5'd7;
      2'd1:    k = 5'd15;
      2'd2:    k = 5'd23;
      default: k = 5'd31;
    endcase
    return k;
  endfunction

  function automatic logic [PCM_W-1:0] full_scale(input logic [MODE_W-1:0] mode);
    return (PCM_W'(1) << full_shift(mode)) - PCM_W'(1);
  endfunction

endpackage

[rtl/core/pcm_output_sample_converter.sv]
// Top level of the PCM output sample converter: frame buffer, channel sequencer and pipeline.
// Depends on pcmosc_pkg for widths, register indexes and the full-scale helpers.
//
// A frame beat is held in a one-frame buffer and the sequencer issues one device channel per
// cycle from it while the output is not stalled, so a frame holds the input side until its
// last device channel issues and a frame with no device channels is taken without issuing.
// The next frame is accepted in the cycle its predecessor issues its last channel, giving one
// output beat per cycle sustained when not stalled. Each sample then passes nine register
// stages (sum, gain multiply, full-scale product, truncation and cap, five stages of divide by
// five at seven bits each) and is dithered and saturated on its way into the output register;
// the whole pipeline holds while the output register is full and not taken. The configuration
// port is always ready, and a register should be written only while no frame is in flight.
module pcm_output_sample_converter (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [pcmosc_pkg::IN_W-1:0]  src_ch0_i,
  input  logic signed [pcmosc_pkg::IN_W-1:0]  src_ch1_i,
  input  logic signed [pcmosc_pkg::IN_W-1:0]  src_ch2_i,
  input  logic signed [pcmosc_pkg::IN_W-1:0]  src_ch3_i,
  input  logic signed [pcmosc_pkg::IN_W-1:0]  src_ch4_i,
  input  logic signed [pcmosc_pkg::IN_W-1:0]  src_ch5_i,
  input  logic [pcmosc_pkg::MAX_DEV-1:0]      dither_word_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [pcmosc_pkg::PCM_W-1:0] pcm_sample_o,
  output logic [pcmosc_pkg::CH_W-1:0]         out_channel_o,
  output logic                                frame_last_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [pcmosc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [pcmosc_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import pcmosc_pkg::*;

  logic [MODE_W-1:0] mode_q;
  logic [GAIN_W-1:0] gain_q;
  logic              dmx_en_q;
  logic              dith_en_q;
  logic [SRCN_W-1:0] nsrc_q;
  logic [DEV_W-1:0]  ndev_q;

  logic [DEV_W-1:0]  ndev_eff;
  logic [SRCN_W-1:0] nsrc_eff;
  logic              mix;

  logic signed [IN_W-1:0] src_q [SRC_COUNT];
  logic [MAX_DEV-1:0]     dith_q;
  logic                   busy_q, busy_d;
  logic [CH_W-1:0]        ch_q, ch_d;
  logic [SRCN_W-1:0]      sidx_q, sidx_d;

  logic en, issue, is_last, issue_last, in_fire;

  logic signed [IN_W-1:0]  front, back;
  logic signed [SUM_W-1:0] sum_mix, sum_one;
  item_tag_t               tag_issue;

  logic                    s1_vld_q;
  logic signed [SUM_W-1:0] s1_m_q;
  item_tag_t               s1_tag_q;

  logic [MAG_W-1:0]        mag;
  logic                    s2_vld_q;
  logic [X_W-1:0]          s2_x_q;
  item_tag_t               s2_tag_q;

  logic                    s3_vld_q;
  logic [P_W-1:0]          s3_p_q;
  item_tag_t               s3_tag_q;

  logic [P_W-1:0]          y_full;
  logic [Q_W-1:0]          y_cap;

  logic                    dv_vld_q  [DIV_STAGES+1];
  logic [Q_W-1:0]          dv_w_q    [DIV_STAGES+1];
  logic [2:0]              dv_r_q    [DIV_STAGES+1];
  logic [Q_W-1:0]          dv_y_q    [DIV_STAGES+1];
  logic                    dv_frac_q [DIV_STAGES+1];
  item_tag_t               dv_tag_q  [DIV_STAGES+1];
  logic [Q_W-1:0]          nw [DIV_STAGES];
  logic [2:0]              nr [DIV_STAGES];
  logic [3:0]              div_t;

  item_tag_t               ft;
  logic [Q_W-1:0]          q;
  logic                    frac_all;
  logic signed [V_W-1:0]   qs, ds, v, v_sat, lim_hi, lim_lo;
  localparam logic signed [V_W-1:0] V_ONE = V_W'(1);

  logic                    out_vld_q;
  logic signed [PCM_W-1:0] pcm_q;
  logic [CH_W-1:0]         och_q;
  logic                    olast_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= RST_MODE;
      gain_q    <= RST_GAIN;
      dmx_en_q  <= 1'b0;
      dith_en_q <= 1'b0;
      nsrc_q    <= RST_SRC_CH;
      ndev_q    <= RST_DEV_CH;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_SAMPLE_BITS_MODE: mode_q    <= cfg_data_i[MODE_W-1:0];
        CFG_PLAY_GAIN:        gain_q    <= cfg_data_i[GAIN_W-1:0];
        CFG_DOWNMIX_ENABLE:   dmx_en_q  <= cfg_data_i[0];
        CFG_DITHER_ENABLE:    dith_en_q <= cfg_data_i[0];
        CFG_SOURCE_CHANNELS:  nsrc_q    <= cfg_data_i[SRCN_W-1:0];
        CFG_DEVICE_CHANNELS:  ndev_q    <= cfg_data_i[DEV_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    ndev_eff = (ndev_q > DEV_W'(MAX_DEV)) ? DEV_W'(MAX_DEV) : ndev_q;
    if (nsrc_q == '0) begin
      nsrc_eff = SRCN_W'(1);
    end else if (nsrc_q > SRCN_W'(SRC_COUNT)) begin
      nsrc_eff = SRCN_W'(SRC_COUNT);
    end else begin
      nsrc_eff = nsrc_q;
    end
    mix = dmx_en_q && (nsrc_q == SRCN_W'(SRC_COUNT)) && (ndev_q == DEV_W'(2));
  end

  assign en         = !out_vld_q || out_ready_i;
  assign issue      = busy_q && en;
  assign is_last    = ({1'b0, ch_q} == (ndev_eff - DEV_W'(1)));
  assign issue_last = issue && is_last;
  assign in_ready_o = !busy_q || issue_last;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    busy_d = busy_q;
    ch_d   = ch_q;
    sidx_d = sidx_q;
    if (in_fire) begin
      busy_d = (ndev_eff != '0);
      ch_d   = '0;
      sidx_d = '0;
    end else if (issue) begin
      busy_d = !is_last;
      ch_d   = ch_q + CH_W'(1);
      sidx_d = (sidx_q == nsrc_eff - SRCN_W'(1)) ? '0 : sidx_q + SRCN_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      ch_q   <= '0;
      sidx_q <= '0;
    end else begin
      busy_q <= busy_d;
      ch_q   <= ch_d;
      sidx_q <= sidx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      src_q[0] <= src_ch0_i;
      src_q[1] <= src_ch1_i;
      src_q[2] <= src_ch2_i;
      src_q[3] <= src_ch3_i;
      src_q[4] <= src_ch4_i;
      src_q[5] <= src_ch5_i;
      dith_q   <= dither_word_i;
    end
  end

  always_comb begin
    front   = ch_q[0] ? src_q[1] : src_q[0];
    back    = ch_q[0] ? src_q[5] : src_q[4];
    sum_one = {{(SUM_W-IN_W){src_q[sidx_q][IN_W-1]}}, src_q[sidx_q]};
    sum_mix = {{(SUM_W-IN_W){src_q[2][IN_W-1]}}, src_q[2]}
            + {{(SUM_W-IN_W){src_q[3][IN_W-1]}}, src_q[3]}
            + {{(SUM_W-IN_W-1){front[IN_W-1]}}, front, 1'b0}
            + {{(SUM_W-IN_W-1){back[IN_W-1]}}, back, 1'b0};
    tag_issue.ch   = ch_q;
    tag_issue.last = is_last;
    tag_issue.dith = dith_en_q && dith_q[ch_q];
    tag_issue.mix  = mix;
    tag_issue.neg  = mix ? sum_mix[SUM_W-1] : sum_one[SUM_W-1];
  end

  assign mag = s1_m_q[SUM_W-1] ? MAG_W'(-s1_m_q) : MAG_W'(s1_m_q);

  always_comb begin
    y_full = s3_p_q >> SHIFT;
    y_cap  = (y_full > P_W'(Q_CLAMP)) ? Q_CLAMP : y_full[Q_W-1:0];
  end

  always_comb begin
    div_t = '0;
    for (int j = 0; j < DIV_STAGES; j++) begin
      nw[j] = dv_w_q[j];
      nr[j] = dv_r_q[j];
      for (int b = 0; b < DIV_STEP; b++) begin
        div_t = {nr[j], nw[j][Q_W-1-j*DIV_STEP-b]};
        if (div_t >= DIVISOR) begin
          nw[j][Q_W-1-j*DIV_STEP-b] = 1'b1;
          nr[j] = 3'(div_t - DIVISOR);
        end else begin
          nw[j][Q_W-1-j*DIV_STEP-b] = 1'b0;
          nr[j] = div_t[2:0];
        end
      end
    end
  end

  always_comb begin
    ft       = dv_tag_q[DIV_STAGES];
    q        = ft.mix ? dv_w_q[DIV_STAGES] : dv_y_q[DIV_STAGES];
    frac_all = dv_frac_q[DIV_STAGES] || (ft.mix && (dv_r_q[DIV_STAGES] != '0));
    qs       = $signed({2'b00, q});
    ds       = $signed({{(V_W-1){1'b0}}, ft.dith});
    lim_hi   = $signed({{(V_W-PCM_W){1'b0}}, full_scale(mode_q)});
    lim_lo   = -lim_hi - V_ONE;
    if (ft.neg) begin
      v = -(qs + ds);
    end else if (q != '0) begin
      v = qs - ds;
    end else begin
      v = (ft.dith && !frac_all) ? -V_ONE : '0;
    end
    if (v > lim_hi) begin
      v_sat = lim_hi;
    end else if (v < lim_lo) begin
      v_sat = lim_lo;
    end else begin
      v_sat = v;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      for (int j = 0; j <= DIV_STAGES; j++) begin
        dv_vld_q[j] <= 1'b0;
      end
    end else if (en) begin
      s1_vld_q    <= issue;
      s2_vld_q    <= s1_vld_q;
      s3_vld_q    <= s2_vld_q;
      dv_vld_q[0] <= s3_vld_q;
      for (int j = 0; j < DIV_STAGES; j++) begin
        dv_vld_q[j+1] <= dv_vld_q[j];
      end
      out_vld_q   <= dv_vld_q[DIV_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_m_q       <= tag_issue.mix ? sum_mix : sum_one;
      s1_tag_q     <= tag_issue;
      s2_x_q       <= X_W'(mag) * X_W'(gain_q);
      s2_tag_q     <= s1_tag_q;
      s3_p_q       <= (P_W'(s2_x_q) << full_shift(mode_q)) - P_W'(s2_x_q);
      s3_tag_q     <= s2_tag_q;
      dv_w_q[0]    <= y_cap;
      dv_r_q[0]    <= '0;
      dv_y_q[0]    <= y_cap;
      dv_frac_q[0] <= (s3_p_q[SHIFT-1:0] != '0);
      dv_tag_q[0]  <= s3_tag_q;
      for (int j = 0; j < DIV_STAGES; j++) begin
        dv_w_q[j+1]    <= nw[j];
        dv_r_q[j+1]    <= nr[j];
        dv_y_q[j+1]    <= dv_y_q[j];
        dv_frac_q[j+1] <= dv_frac_q[j];
        dv_tag_q[j+1]  <= dv_tag_q[j];
      end
      pcm_q   <= v_sat[PCM_W-1:0];
      och_q   <= ft.ch;
      olast_q <= ft.last;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign pcm_sample_o  = pcm_q;
  assign out_channel_o = och_q;
  assign frame_last_o  = olast_q;

endmodule

[rtl/core/pcmosc_checker.sv]
// Port-level checker for the PCM output sample converter, with its bind statement.
// Depends on pcmosc_pkg for widths; sees only the ports of the top level.
module pcmosc_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                out_valid_i,
  input logic                                out_ready_i,
  input logic signed [pcmosc_pkg::PCM_W-1:0] pcm_sample_i,
  input logic [pcmosc_pkg::CH_W-1:0]         out_channel_i,
  input logic                                frame_last_i
);
  import pcmosc_pkg::*;

  logic [CH_W-1:0] exp_ch_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_ch_q <= '0;
    end else if (out_valid_i && out_ready_i) begin
      exp_ch_q <= frame_last_i ? '0 : out_channel_i + CH_W'(1);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(pcm_sample_i)
      && $stable(out_channel_i) && $stable(frame_last_i))
    else $error("output beat changed while stalled");

  a_ch_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_channel_i == exp_ch_q)
    else $error("device channel out of sequence");

  a_last_ch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_channel_i == CH_W'(MAX_DEV - 1)) |-> frame_last_i)
    else $error("highest device channel not flagged as last");

endmodule

bind pcm_output_sample_converter pcmosc_checker u_pcmosc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .pcm_sample_i  (pcm_sample_o),
  .out_channel_i (out_channel_o),
  .frame_last_i  (frame_last_o)
);
